[rtl/core/rps_pkg.sv]
// shared constants and transaction types for the roulette parent selector
package rps_pkg;

	localparam int POP_MAX    = 64;
	localparam int SCORE_BITS = 24;
	localparam int FRAC_BITS  = 16;

	localparam int ID_W      = $clog2(POP_MAX);
	localparam int CNT_W     = $clog2(POP_MAX + 1);
	localparam int RATIO_W   = FRAC_BITS + 1;
	localparam int TOTAL_W   = SCORE_BITS + ID_W;
	localparam int ACC_W     = FRAC_BITS + ID_W + 1;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_EVAL   = 2'd1;
	localparam logic [1:0] CMD_SELECT = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_SELECTED  = 2'd0;
	localparam logic [1:0] ST_FALLBACK  = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_ACK       = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  slot;
		logic [23:0] score;
		logic [15:0] random_fraction;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  entry_id;
		logic [16:0] entry_ratio;
		logic [29:0] total_score;
	} out_t;

endpackage

[rtl/core/roulette_parent_selector.sv]
// top level of the roulette parent selector: control, scoring, ranking and walk
// Load and clear transactions complete at once: the result appears the cycle after start
// and busy stays low. An evaluate sums the n scores in use, runs the 17-step restoring
// divide for each slot in use while the total is nonzero, passes once over each other
// slot of the 64, and counts the rank of each slot in use, since every comparison is a
// read through the single read port of the ratio memory, then reads back the first
// entry. A select reads the order memory and then the ratio memory for each step of
// the walk; a zero-ratio fallback or an exhausted walk adds a read of the last entry.
// Results come on a one-cycle done strobe and cannot be stalled. Configuration must be
// written only while idle; the block itself does not enforce this.
module roulette_parent_selector (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rps_pkg::in_t  item,
	output logic          done,
	output rps_pkg::out_t result,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata
);
	import rps_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_SUM_RD  = 12'b000000000010,
		S_SUM_ACC = 12'b000000000100,
		S_DIV_RD  = 12'b000000001000,
		S_DIV_LD  = 12'b000000010000,
		S_DIV_RUN = 12'b000000100000,
		S_RANK_RD = 12'b000001000000,
		S_RANK    = 12'b000010000000,
		S_RANK_WR = 12'b000100000000,
		S_SEL_ORD = 12'b001000000000,
		S_SEL_RAT = 12'b010000000000,
		S_SEL_CHK = 12'b100000000000
	} state_t;

	// finishing reads share the select read states, flagged by fin_q
	state_t              state_q;
	logic                fin_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    jdx_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  rem_q;
	logic                nbit_q;
	logic [RATIO_W-1:0]  quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [RATIO_W-1:0]  ratio_i_q;
	logic [ID_W-1:0]     rank_q;
	logic                cmp_v_q;
	logic [ID_W-1:0]     cmp_j_q;
	logic [ACC_W-1:0]    acc_q;
	logic [15:0]         rnd_q;
	logic [ID_W-1:0]     pos_q;
	logic [1:0]          status_q;
	logic [ID_W-1:0]     cur_e_q;
	logic                evaluated_q;
	logic [POP_MAX-1:0]  marks_q;
	logic [ID_W-1:0]     od_raddr_q;
	logic                done_q;
	out_t                out_q;

	// memory ports
	logic                sc_we;
	logic [ID_W-1:0]     sc_raddr;
	logic [SCORE_BITS-1:0] sc_rdata;
	logic                rt_we;
	logic [ID_W-1:0]     rt_waddr, rt_raddr;
	logic [RATIO_W-1:0]  rt_wdata, rt_rdata_raw, ratio_rd;
	logic                od_we;
	logic [ID_W-1:0]     od_waddr, od_wdata, od_raddr, od_rdata_raw, order_rd;

	// divide step
	logic [TOTAL_W:0]    div_t;
	logic                div_ge;
	logic [TOTAL_W-1:0]  rem_next;
	logic [RATIO_W-1:0]  quo_next;
	logic                div_last;

	logic [ACC_W-1:0]    walk_sum;
	logic [ID_W-1:0]     last_pos;
	logic                active_i;

	// before the first evaluate the ratios read as zero and the order as identity
	assign ratio_rd = evaluated_q ? rt_rdata_raw : '0;
	assign order_rd = evaluated_q ? od_rdata_raw : od_raddr_q;

	assign div_t    = {rem_q, nbit_q};
	assign div_ge   = div_t >= {1'b0, total_q};
	assign rem_next = div_ge ? TOTAL_W'(div_t - {1'b0, total_q}) : div_t[TOTAL_W-1:0];
	assign quo_next = {quo_q[RATIO_W-2:0], div_ge};
	assign div_last = step_q == STEP_W'(DIV_STEPS - 1);

	assign walk_sum = acc_q + ACC_W'(ratio_rd);
	assign last_pos = ID_W'(cnt_q - CNT_W'(1));
	assign active_i = (idx_q < cnt_q) && (total_q != '0);

	always_comb begin
		sc_we    = 1'b0;
		sc_raddr = idx_q[ID_W-1:0];
		rt_we    = 1'b0;
		rt_waddr = idx_q[ID_W-1:0];
		rt_wdata = quo_next;
		rt_raddr = idx_q[ID_W-1:0];
		od_we    = 1'b0;
		od_waddr = idx_q[ID_W-1:0];
		od_wdata = idx_q[ID_W-1:0];
		od_raddr = fin_q ? pos_q : idx_q[ID_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				sc_we = start && (item.cmd == CMD_LOAD) &&
					({1'b0, item.slot} < 7'(POP_MAX));
			end
			S_DIV_RD: begin
				// inactive slot or zero total: ratio zero, order identity
				if (!active_i) begin
					rt_we    = 1'b1;
					rt_wdata = '0;
					od_we    = 1'b1;
				end
			end
			S_DIV_RUN: begin
				if (div_last) begin
					rt_we = 1'b1;
					od_we = 1'b1;
				end
			end
			S_RANK: rt_raddr = jdx_q[ID_W-1:0];
			S_RANK_WR: begin
				od_we    = 1'b1;
				od_waddr = rank_q;
			end
			S_SEL_RAT: rt_raddr = order_rd;
			default: ;
		endcase
	end

	rps_ram #(.WIDTH(SCORE_BITS), .DEPTH(POP_MAX)) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (item.slot[ID_W-1:0]),
		.wdata (item.score),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	rps_ram #(.WIDTH(RATIO_W), .DEPTH(POP_MAX)) u_ratio_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (rt_raddr),
		.rdata (rt_rdata_raw)
	);

	rps_ram #(.WIDTH(ID_W), .DEPTH(POP_MAX)) u_order_ram (
		.clk   (clk),
		.we    (od_we),
		.waddr (od_waddr),
		.wdata (od_wdata),
		.raddr (od_raddr),
		.rdata (od_rdata_raw)
	);

	always_ff @(posedge clk) begin
		od_raddr_q <= od_raddr;
	end

	// population count, clamped to the legal range when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(POP_MAX);
		end else if (cfg_we) begin
			if (CNT_W'(cfg_wdata) < CNT_W'(2)) begin
				cnt_q <= CNT_W'(2);
			end else if (CNT_W'(cfg_wdata) > CNT_W'(POP_MAX)) begin
				cnt_q <= CNT_W'(POP_MAX);
			end else begin
				cnt_q <= CNT_W'(cfg_wdata);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fin_q       <= 1'b0;
			evaluated_q <= 1'b0;
			marks_q     <= '0;
			total_q     <= '0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			jdx_q       <= '0;
			rem_q       <= '0;
			nbit_q      <= 1'b0;
			quo_q       <= '0;
			step_q      <= '0;
			ratio_i_q   <= '0;
			rank_q      <= '0;
			cmp_v_q     <= 1'b0;
			cmp_j_q     <= '0;
			acc_q       <= '0;
			rnd_q       <= '0;
			pos_q       <= '0;
			status_q    <= ST_ACK;
			cur_e_q     <= '0;
			out_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						out_q.status      <= ST_ACK;
						out_q.entry_id    <= '0;
						out_q.entry_ratio <= '0;
						out_q.total_score <= total_q;
						idx_q             <= '0;
						unique case (item.cmd)
							CMD_LOAD: done_q <= 1'b1;
							CMD_CLEAR: begin
								marks_q <= '0;
								done_q  <= 1'b1;
							end
							CMD_EVAL: begin
								total_q <= '0;
								state_q <= S_SUM_RD;
							end
							CMD_SELECT: begin
								acc_q   <= '0;
								rnd_q   <= item.random_fraction;
								fin_q   <= 1'b0;
								state_q <= S_SEL_ORD;
							end
							default: ;
						endcase
					end
				end
				S_SUM_RD: state_q <= S_SUM_ACC;
				S_SUM_ACC: begin
					total_q <= total_q + TOTAL_W'(sc_rdata);
					if (idx_q == cnt_q - CNT_W'(1)) begin
						idx_q   <= '0;
						state_q <= S_DIV_RD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SUM_RD;
					end
				end
				S_DIV_RD: begin
					if (active_i) begin
						state_q <= S_DIV_LD;
					end else if (idx_q == CNT_W'(POP_MAX - 1)) begin
						idx_q       <= '0;
						evaluated_q <= 1'b1;
						state_q     <= S_RANK_RD;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_DIV_LD: begin
					// dividend is score shifted up by the fraction width
					rem_q   <= TOTAL_W'(sc_rdata >> 1);
					nbit_q  <= sc_rdata[0];
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					nbit_q <= 1'b0;
					step_q <= step_q + STEP_W'(1);
					if (div_last) begin
						if (idx_q == CNT_W'(POP_MAX - 1)) begin
							idx_q       <= '0;
							evaluated_q <= 1'b1;
							state_q     <= S_RANK_RD;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_DIV_RD;
						end
					end
				end
				S_RANK_RD: begin
					jdx_q   <= '0;
					rank_q  <= '0;
					cmp_v_q <= 1'b0;
					state_q <= S_RANK;
				end
				S_RANK: begin
					// first cycle captures ratio of entry i, then sweep all j
					if (jdx_q == '0 && !cmp_v_q) begin
						ratio_i_q <= ratio_rd;
					end
					if (cmp_v_q) begin
						if ((ratio_rd > ratio_i_q) ||
							((ratio_rd == ratio_i_q) && (cmp_j_q < idx_q[ID_W-1:0]))) begin
							rank_q <= rank_q + ID_W'(1);
						end
					end
					if (jdx_q < cnt_q) begin
						cmp_v_q <= 1'b1;
						cmp_j_q <= jdx_q[ID_W-1:0];
						jdx_q   <= jdx_q + CNT_W'(1);
					end else begin
						cmp_v_q <= 1'b0;
						if (!cmp_v_q) begin
							state_q <= S_RANK_WR;
						end
					end
				end
				S_RANK_WR: begin
					if (idx_q == cnt_q - CNT_W'(1)) begin
						pos_q    <= '0;
						status_q <= ST_ACK;
						fin_q    <= 1'b1;
						state_q  <= S_SEL_ORD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_RANK_RD;
					end
				end
				S_SEL_ORD: state_q <= S_SEL_RAT;
				S_SEL_RAT: begin
					cur_e_q <= order_rd;
					state_q <= S_SEL_CHK;
				end
				S_SEL_CHK: begin
					if (fin_q) begin
						// finishing read of the first or last entry in use
						out_q.status      <= status_q;
						out_q.entry_id    <= cur_e_q;
						out_q.entry_ratio <= ratio_rd;
						out_q.total_score <= total_q;
						done_q            <= 1'b1;
						fin_q             <= 1'b0;
						state_q           <= S_IDLE;
					end else if ((ACC_W'(rnd_q) <= walk_sum) && !marks_q[cur_e_q]) begin
						marks_q[cur_e_q]  <= 1'b1;
						out_q.status      <= ST_SELECTED;
						out_q.entry_id    <= cur_e_q;
						out_q.entry_ratio <= ratio_rd;
						out_q.total_score <= total_q;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else if (ratio_rd == '0) begin
						status_q <= ST_FALLBACK;
						pos_q    <= last_pos;
						fin_q    <= 1'b1;
						state_q  <= S_SEL_ORD;
					end else if (idx_q == cnt_q - CNT_W'(1)) begin
						status_q <= ST_EXHAUSTED;
						pos_q    <= last_pos;
						fin_q    <= 1'b1;
						state_q  <= S_SEL_ORD;
					end else begin
						acc_q   <= walk_sum;
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SEL_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = out_q;
endmodule

[rtl/core/rps_ram.sv]
// generic single-port-write ram with registered read
module rps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
